// ----- hdl/scc_pkg.sv -----
`timescale 1ns / 1ps

package scc_pkg;

    localparam int NODE_W = 6;
    localparam int CNT_W  = 7;

    typedef struct packed {
        logic [NODE_W-1:0] edge_source;
        logic [NODE_W-1:0] edge_target;
        logic              edge_present;
        logic              last_edge;
    } edge_req_t;

    typedef struct packed {
        logic [NODE_W-1:0] node_id;
        logic [NODE_W-1:0] component_id;
        logic              component_end;
        logic              last_result;
        logic              dropped_edges;
    } result_req_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_F_START,
        OP_F_ROOT_SKIP,
        OP_F_ROOT_PUSH,
        OP_F_READ,
        OP_F_CHECK,
        OP_F_FINISH,
        OP_POP_READ,
        OP_POP_LOAD,
        OP_POP_LAST,
        OP_R_START,
        OP_R_READ,
        OP_R_ROOT,
        OP_R_SCAN_INIT,
        OP_R_EDGE_READ,
        OP_R_EDGE_CHECK,
        OP_R_PUSH,
        OP_C_END,
        OP_FINAL
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F_START,
        ST_F_ROOT,
        ST_F_SCAN,
        ST_F_CHECK,
        ST_F_POP,
        ST_F_POPW,
        ST_R_NEXT,
        ST_R_GET,
        ST_R_SINIT,
        ST_R_SRD,
        ST_R_SCHK,
        ST_R_POP,
        ST_R_POPW,
        ST_R_FINAL
    } state_t;

    typedef struct packed {
        logic r_end;
        logic r_marked;
        logic f_scan_end;
        logic f_hit;
        logic sp_one;
        logic k_zero;
        logic v_marked;
        logic r_scan_end;
        logic best_found;
        logic emit_ok;
        logic final_ok;
    } status_t;

endpackage

// ----- hdl/scc_ctrl.sv -----
`timescale 1ns / 1ps

module scc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              edge_valid,
    input  logic              edge_last,
    input  scc_pkg::status_t  status,
    output logic              edge_ready,
    output scc_pkg::op_t      cmd
);

    scc_pkg::state_t state_reg;
    scc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scc_pkg::ST_IDLE:
            begin
                if (edge_valid && edge_last)
                begin
                    state_next = scc_pkg::ST_F_START;
                end
            end
            scc_pkg::ST_F_START: state_next = scc_pkg::ST_F_ROOT;
            scc_pkg::ST_F_ROOT:
            begin
                if (status.r_end)
                begin
                    state_next = scc_pkg::ST_R_NEXT;
                end
                else if (!status.r_marked)
                begin
                    state_next = scc_pkg::ST_F_SCAN;
                end
            end
            scc_pkg::ST_F_SCAN:
            begin
                state_next = status.f_scan_end ? scc_pkg::ST_F_POP : scc_pkg::ST_F_CHECK;
            end
            scc_pkg::ST_F_CHECK: state_next = scc_pkg::ST_F_SCAN;
            scc_pkg::ST_F_POP:
            begin
                state_next = status.sp_one ? scc_pkg::ST_F_ROOT : scc_pkg::ST_F_POPW;
            end
            scc_pkg::ST_F_POPW: state_next = scc_pkg::ST_F_SCAN;
            scc_pkg::ST_R_NEXT:
            begin
                state_next = status.k_zero ? scc_pkg::ST_R_FINAL : scc_pkg::ST_R_GET;
            end
            scc_pkg::ST_R_GET:
            begin
                if (status.v_marked)
                begin
                    state_next = scc_pkg::ST_R_NEXT;
                end
                else if (status.emit_ok)
                begin
                    state_next = scc_pkg::ST_R_SINIT;
                end
            end
            scc_pkg::ST_R_SINIT: state_next = scc_pkg::ST_R_SRD;
            scc_pkg::ST_R_SRD:
            begin
                if (!status.r_scan_end)
                begin
                    state_next = scc_pkg::ST_R_SCHK;
                end
                else if (!status.best_found)
                begin
                    state_next = scc_pkg::ST_R_POP;
                end
                else if (status.emit_ok)
                begin
                    state_next = scc_pkg::ST_R_SINIT;
                end
            end
            scc_pkg::ST_R_SCHK: state_next = scc_pkg::ST_R_SRD;
            scc_pkg::ST_R_POP:
            begin
                state_next = status.sp_one ? scc_pkg::ST_R_NEXT : scc_pkg::ST_R_POPW;
            end
            scc_pkg::ST_R_POPW: state_next = scc_pkg::ST_R_SINIT;
            scc_pkg::ST_R_FINAL:
            begin
                if (status.final_ok)
                begin
                    state_next = scc_pkg::ST_IDLE;
                end
            end
            default: state_next = scc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = scc_pkg::OP_NONE;
        edge_ready = 1'b0;
        case (state_reg)
            scc_pkg::ST_IDLE:
            begin
                edge_ready = 1'b1;
                if (edge_valid)
                begin
                    cmd = scc_pkg::OP_LOAD;
                end
            end
            scc_pkg::ST_F_START: cmd = scc_pkg::OP_F_START;
            scc_pkg::ST_F_ROOT:
            begin
                if (status.r_end)
                begin
                    cmd = scc_pkg::OP_R_START;
                end
                else if (status.r_marked)
                begin
                    cmd = scc_pkg::OP_F_ROOT_SKIP;
                end
                else
                begin
                    cmd = scc_pkg::OP_F_ROOT_PUSH;
                end
            end
            scc_pkg::ST_F_SCAN:
            begin
                cmd = status.f_scan_end ? scc_pkg::OP_F_FINISH : scc_pkg::OP_F_READ;
            end
            scc_pkg::ST_F_CHECK: cmd = scc_pkg::OP_F_CHECK;
            scc_pkg::ST_F_POP, scc_pkg::ST_R_POP:
            begin
                if (!status.sp_one)
                begin
                    cmd = scc_pkg::OP_POP_READ;
                end
                else if (state_reg == scc_pkg::ST_F_POP)
                begin
                    cmd = scc_pkg::OP_POP_LAST;
                end
                else
                begin
                    cmd = scc_pkg::OP_C_END;
                end
            end
            scc_pkg::ST_F_POPW, scc_pkg::ST_R_POPW: cmd = scc_pkg::OP_POP_LOAD;
            scc_pkg::ST_R_NEXT:
            begin
                if (!status.k_zero)
                begin
                    cmd = scc_pkg::OP_R_READ;
                end
            end
            scc_pkg::ST_R_GET:
            begin
                if (!status.v_marked && status.emit_ok)
                begin
                    cmd = scc_pkg::OP_R_ROOT;
                end
            end
            scc_pkg::ST_R_SINIT: cmd = scc_pkg::OP_R_SCAN_INIT;
            scc_pkg::ST_R_SRD:
            begin
                if (!status.r_scan_end)
                begin
                    cmd = scc_pkg::OP_R_EDGE_READ;
                end
                else if (status.best_found && status.emit_ok)
                begin
                    cmd = scc_pkg::OP_R_PUSH;
                end
            end
            scc_pkg::ST_R_SCHK: cmd = scc_pkg::OP_R_EDGE_CHECK;
            scc_pkg::ST_R_FINAL:
            begin
                if (status.final_ok)
                begin
                    cmd = scc_pkg::OP_FINAL;
                end
            end
            default: cmd = scc_pkg::OP_NONE;
        endcase
    end

endmodule

// ----- hdl/scc_dp.sv -----
`timescale 1ns / 1ps

module scc_dp #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  scc_pkg::op_t              cmd,
    input  scc_pkg::edge_req_t        edge_req,
    input  logic                      cfg_we,
    input  logic [scc_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                      result_ready,
    output logic                      result_valid,
    output scc_pkg::result_req_t      result_req,
    output scc_pkg::status_t          status
);

    localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int SAW = $clog2(MAX_NODES);
    localparam int SPW = $clog2(MAX_NODES + 1);
    localparam int CW  = (EW > scc_pkg::CNT_W) ? EW : scc_pkg::CNT_W;
    localparam int NW  = scc_pkg::NODE_W;

    logic [scc_pkg::CNT_W-1:0] n_reg;
    logic [EW-1:0]             total_reg;
    logic                      ovf_reg;
    logic [MAX_NODES-1:0]      marks_reg;
    logic [scc_pkg::CNT_W-1:0] r_reg;
    logic [SPW-1:0]            fcount_reg;
    logic [SPW-1:0]            k_reg;
    logic [SPW-1:0]            sp_reg;
    logic [NW-1:0]             top_node_reg;
    logic [CW-1:0]             top_cur_reg;
    logic [EW-1:0]             scan_idx_reg;
    logic                      best_valid_reg;
    logic [NW-1:0]             best_reg;
    logic [NW-1:0]             comp_reg;
    logic                      pend_valid_reg;
    scc_pkg::result_req_t      pend_reg;
    logic                      out_valid_reg;
    scc_pkg::result_req_t      out_reg;

    logic [NW-1:0] src_mem [MAX_EDGES];
    logic [NW-1:0] tgt_mem [MAX_EDGES];
    logic [NW-1:0] rd_src_reg;
    logic [NW-1:0] rd_tgt_reg;
    logic [NW-1:0] stk_node_mem [MAX_NODES];
    logic [CW-1:0] stk_cur_mem  [MAX_NODES];
    logic [NW-1:0] stk_rd_node_reg;
    logic [CW-1:0] stk_rd_cur_reg;
    logic [NW-1:0] fin_mem [MAX_NODES];
    logic [NW-1:0] fin_rd_reg;

    logic          load_ok;
    logic          emit;
    logic [NW-1:0] emit_node;
    logic          rev_hit;
    logic [SPW-1:0] push_addr;
    logic [SPW-1:0] pop_addr;
    logic [SPW-1:0] k_addr;
    logic [CW-1:0]  edge_addr;
    logic           stk_we;
    logic [CW-1:0]  stk_wcur;

    assign load_ok = edge_req.edge_present
                  && ({1'b0, edge_req.edge_source} < n_reg)
                  && ({1'b0, edge_req.edge_target} < n_reg)
                  && (total_reg < EW'(MAX_EDGES));

    assign emit      = (cmd == scc_pkg::OP_R_ROOT) || (cmd == scc_pkg::OP_R_PUSH);
    assign emit_node = (cmd == scc_pkg::OP_R_PUSH) ? best_reg : fin_rd_reg;

    assign rev_hit = (rd_tgt_reg == top_node_reg)
                  && ({1'b0, rd_src_reg} < n_reg)
                  && !marks_reg[rd_src_reg[SAW-1:0]]
                  && (CW'(rd_src_reg) >= top_cur_reg)
                  && (!best_valid_reg || (rd_src_reg < best_reg));

    assign push_addr = sp_reg - SPW'(1);
    assign pop_addr  = sp_reg - SPW'(2);
    assign k_addr    = k_reg - SPW'(1);
    assign edge_addr = (cmd == scc_pkg::OP_F_READ) ? top_cur_reg : CW'(scan_idx_reg);

    assign stk_we   = ((cmd == scc_pkg::OP_F_CHECK) && status.f_hit)
                   || (cmd == scc_pkg::OP_R_PUSH);
    assign stk_wcur = (cmd == scc_pkg::OP_R_PUSH) ? (CW'(best_reg) + CW'(1))
                                                  : (top_cur_reg + CW'(1));

    always_comb
    begin
        status.r_end      = (r_reg == n_reg);
        status.r_marked   = marks_reg[r_reg[SAW-1:0]];
        status.f_scan_end = (top_cur_reg >= CW'(total_reg));
        status.f_hit      = (rd_src_reg == top_node_reg)
                         && ({1'b0, rd_tgt_reg} < n_reg)
                         && !marks_reg[rd_tgt_reg[SAW-1:0]];
        status.sp_one     = (sp_reg == SPW'(1));
        status.k_zero     = (k_reg == '0);
        status.v_marked   = marks_reg[fin_rd_reg[SAW-1:0]];
        status.r_scan_end = (scan_idx_reg == total_reg);
        status.best_found = best_valid_reg;
        status.emit_ok    = !(pend_valid_reg && out_valid_reg && !result_ready);
        status.final_ok   = !out_valid_reg || result_ready;
    end

    always_ff @(posedge clk)
    begin
        if ((cmd == scc_pkg::OP_LOAD) && load_ok)
        begin
            src_mem[total_reg[AW-1:0]] <= edge_req.edge_source;
            tgt_mem[total_reg[AW-1:0]] <= edge_req.edge_target;
        end
        if ((cmd == scc_pkg::OP_F_READ) || (cmd == scc_pkg::OP_R_EDGE_READ))
        begin
            rd_src_reg <= src_mem[edge_addr[AW-1:0]];
            rd_tgt_reg <= tgt_mem[edge_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_node_mem[push_addr[SAW-1:0]] <= top_node_reg;
            stk_cur_mem[push_addr[SAW-1:0]]  <= stk_wcur;
        end
        if (cmd == scc_pkg::OP_POP_READ)
        begin
            stk_rd_node_reg <= stk_node_mem[pop_addr[SAW-1:0]];
            stk_rd_cur_reg  <= stk_cur_mem[pop_addr[SAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == scc_pkg::OP_F_FINISH)
        begin
            fin_mem[fcount_reg[SAW-1:0]] <= top_node_reg;
        end
        if (cmd == scc_pkg::OP_R_READ)
        begin
            fin_rd_reg <= fin_mem[k_addr[SAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == scc_pkg::OP_R_SCAN_INIT)
        begin
            best_reg <= '0;
        end
        else if ((cmd == scc_pkg::OP_R_EDGE_CHECK) && rev_hit)
        begin
            best_reg <= rd_src_reg;
        end
        if (emit)
        begin
            pend_reg.node_id       <= emit_node;
            pend_reg.component_id  <= comp_reg;
            pend_reg.component_end <= 1'b0;
            pend_reg.last_result   <= 1'b0;
            pend_reg.dropped_edges <= ovf_reg;
        end
        else if (cmd == scc_pkg::OP_C_END)
        begin
            pend_reg.component_end <= 1'b1;
        end
        if (emit && pend_valid_reg)
        begin
            out_reg <= pend_reg;
        end
        else if (cmd == scc_pkg::OP_FINAL)
        begin
            out_reg <= {pend_reg.node_id, pend_reg.component_id,
                        pend_reg.component_end, 1'b1, pend_reg.dropped_edges};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg          <= scc_pkg::CNT_W'(MAX_NODES);
            total_reg      <= '0;
            ovf_reg        <= 1'b0;
            marks_reg      <= '0;
            r_reg          <= '0;
            fcount_reg     <= '0;
            k_reg          <= '0;
            sp_reg         <= '0;
            top_node_reg   <= '0;
            top_cur_reg    <= '0;
            scan_idx_reg   <= '0;
            best_valid_reg <= 1'b0;
            comp_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_wdata == '0)
                begin
                    n_reg <= scc_pkg::CNT_W'(1);
                end
                else if (cfg_wdata > scc_pkg::CNT_W'(MAX_NODES))
                begin
                    n_reg <= scc_pkg::CNT_W'(MAX_NODES);
                end
                else
                begin
                    n_reg <= cfg_wdata;
                end
            end
            if ((emit && pend_valid_reg) || (cmd == scc_pkg::OP_FINAL))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (emit)
            begin
                marks_reg[emit_node[SAW-1:0]] <= 1'b1;
                pend_valid_reg                <= 1'b1;
            end
            case (cmd)
                scc_pkg::OP_LOAD:
                begin
                    if (load_ok)
                    begin
                        total_reg <= total_reg + EW'(1);
                    end
                    else if (edge_req.edge_present)
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                scc_pkg::OP_F_START:
                begin
                    marks_reg  <= '0;
                    r_reg      <= '0;
                    fcount_reg <= '0;
                end
                scc_pkg::OP_F_ROOT_SKIP:
                begin
                    r_reg <= r_reg + scc_pkg::CNT_W'(1);
                end
                scc_pkg::OP_F_ROOT_PUSH:
                begin
                    marks_reg[r_reg[SAW-1:0]] <= 1'b1;
                    top_node_reg <= r_reg[NW-1:0];
                    top_cur_reg  <= '0;
                    sp_reg       <= SPW'(1);
                    r_reg        <= r_reg + scc_pkg::CNT_W'(1);
                end
                scc_pkg::OP_F_CHECK:
                begin
                    if (status.f_hit)
                    begin
                        marks_reg[rd_tgt_reg[SAW-1:0]] <= 1'b1;
                        top_node_reg <= rd_tgt_reg;
                        top_cur_reg  <= '0;
                        sp_reg       <= sp_reg + SPW'(1);
                    end
                    else
                    begin
                        top_cur_reg <= top_cur_reg + CW'(1);
                    end
                end
                scc_pkg::OP_F_FINISH:
                begin
                    fcount_reg <= fcount_reg + SPW'(1);
                end
                scc_pkg::OP_POP_LOAD:
                begin
                    top_node_reg <= stk_rd_node_reg;
                    top_cur_reg  <= stk_rd_cur_reg;
                    sp_reg       <= sp_reg - SPW'(1);
                end
                scc_pkg::OP_POP_LAST:
                begin
                    sp_reg <= '0;
                end
                scc_pkg::OP_R_START:
                begin
                    marks_reg <= '0;
                    k_reg     <= fcount_reg;
                    comp_reg  <= '0;
                end
                scc_pkg::OP_R_READ:
                begin
                    k_reg <= k_reg - SPW'(1);
                end
                scc_pkg::OP_R_ROOT:
                begin
                    top_node_reg <= fin_rd_reg;
                    top_cur_reg  <= '0;
                    sp_reg       <= SPW'(1);
                end
                scc_pkg::OP_R_SCAN_INIT:
                begin
                    scan_idx_reg   <= '0;
                    best_valid_reg <= 1'b0;
                end
                scc_pkg::OP_R_EDGE_READ:
                begin
                    scan_idx_reg <= scan_idx_reg + EW'(1);
                end
                scc_pkg::OP_R_EDGE_CHECK:
                begin
                    if (rev_hit)
                    begin
                        best_valid_reg <= 1'b1;
                    end
                end
                scc_pkg::OP_R_PUSH:
                begin
                    top_node_reg <= best_reg;
                    top_cur_reg  <= '0;
                    sp_reg       <= sp_reg + SPW'(1);
                end
                scc_pkg::OP_C_END:
                begin
                    sp_reg   <= '0;
                    comp_reg <= comp_reg + NW'(1);
                end
                scc_pkg::OP_FINAL:
                begin
                    pend_valid_reg <= 1'b0;
                    total_reg      <= '0;
                    ovf_reg        <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result_req   = out_reg;

endmodule

// ----- hdl/strongly_connected_components.sv -----
// Strongly connected components of a directed graph (Kosaraju).
// Edge channel: edge_valid/edge_ready/edge_req. Each request carries one
// edge (edge_present) and/or the last_edge flag; edges load one per idle cycle.
// Edges naming a node at or above node_count, or beyond MAX_EDGES, are
// dropped and reported in dropped_edges of every result of that graph.
// The request with last_edge starts the walk; edge_ready stays low until the
// whole answer has been handed to the result register.
// Result channel: result_valid/result_ready/result_req, exactly node_count
// requests per graph, in reversed-graph preorder with component number,
// component_end and last_result flags.
// Both walks scan the edge memory one entry at a time, a read state then a
// check state (one read port, registered read). The forward pass resumes
// each node's scan where it stopped; the reverse pass rescans the whole
// edge list after each root, push or pop.
// A stalled receiver holds one result in the output register and one pending;
// the walk waits while both are full.
// Reset: node_count is MAX_NODES, edge memory empty, no clearing pass.
// cfg_we/cfg_wdata write node_count (0 reads as 1, large values clamp).
`timescale 1ns / 1ps

module strongly_connected_components #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      edge_valid,
    output logic                      edge_ready,
    input  scc_pkg::edge_req_t        edge_req,
    output logic                      result_valid,
    input  logic                      result_ready,
    output scc_pkg::result_req_t      result_req,
    input  logic                      cfg_we,
    input  logic [scc_pkg::CNT_W-1:0] cfg_wdata
);

    scc_pkg::op_t     cmd;
    scc_pkg::status_t status;

    scc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_valid (edge_valid),
        .edge_last  (edge_req.last_edge),
        .status     (status),
        .edge_ready (edge_ready),
        .cmd        (cmd)
    );

    scc_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .edge_req     (edge_req),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result_req   (result_req),
        .status       (status)
    );

`ifndef ASSERT_OFF
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == scc_pkg::OP_R_ROOT || cmd == scc_pkg::OP_R_PUSH) |-> status.emit_ok)
        else $error("emit without room");

    a_final_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == scc_pkg::OP_FINAL) |=> result_valid && result_req.last_result)
        else $error("final result lost");

    a_load_hs: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == scc_pkg::OP_LOAD) |-> (edge_valid && edge_ready))
        else $error("load without request");
`endif

endmodule

// ----- verif/strongly_connected_components_tb.sv -----
`timescale 1ns / 1ps

module strongly_connected_components_tb;

    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;
    localparam int SETTLE = 20;
    localparam int STALL_LIMIT = 500000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 edge_valid = 1'b0;
    logic                 edge_ready;
    scc_pkg::edge_req_t   edge_req = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    scc_pkg::result_req_t result_req;
    logic                 cfg_we = 1'b0;
    logic [scc_pkg::CNT_W-1:0] cfg_wdata = '0;

    strongly_connected_components #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .edge_valid(edge_valid),
        .edge_ready(edge_ready),
        .edge_req(edge_req),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result_req(result_req),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // graph copy held by the predictor
    logic [5:0]           graph_src [MAX_EDGES];
    logic [5:0]           graph_dst [MAX_EDGES];
    int                   graph_edges;
    bit                   graph_dropped;
    int                   active_nodes;
    bit [63:0]            seen;
    logic [5:0]           finish_seq [MAX_NODES];
    logic [5:0]           walk_node [MAX_NODES];
    int                   walk_cur [MAX_NODES];
    scc_pkg::result_req_t answer [MAX_NODES];
    int                   answer_len;
    scc_pkg::result_req_t pending_results [$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;

    typedef struct {
        bit                   wr;
        logic [6:0]           val;
        scc_pkg::edge_req_t   req;
        bit                   typed;
        scc_pkg::result_req_t want;
    } step_t;

    step_t plan [$];

    function automatic scc_pkg::edge_req_t mk_edge(int s, int t, bit p, bit l);
        scc_pkg::edge_req_t r;
        r.edge_source = s[5:0];
        r.edge_target = t[5:0];
        r.edge_present = p;
        r.last_edge = l;
        return r;
    endfunction

    function automatic scc_pkg::result_req_t mk_res(int v, int c, bit e, bit l, bit d);
        scc_pkg::result_req_t r;
        r.node_id = v[5:0];
        r.component_id = c[5:0];
        r.component_end = e;
        r.last_result = l;
        r.dropped_edges = d;
        return r;
    endfunction

    function automatic void set_nodes(logic [6:0] raw);
        int v;
        v = raw;
        if (v < 1)
            v = 1;
        if (v > MAX_NODES)
            v = MAX_NODES;
        active_nodes = v;
    endfunction

    function automatic bit has_edge(int f, int t);
        for (int i = 0; i < graph_edges; i++)
            if (graph_src[i] == f && graph_dst[i] == t)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void add_answer(int v, int c);
        answer[answer_len] = mk_res(v, c, 1'b0, 1'b0, graph_dropped);
        answer_len++;
    endfunction

    // updates the graph copy; fills answer[] when the request closes a graph
    function automatic void compute_components(scc_pkg::edge_req_t r);
        int n, fc, sp, u, i, t, s, v, comp;
        bit found;
        n = active_nodes;
        answer_len = 0;
        if (r.edge_present)
        begin
            if (r.edge_source >= n || r.edge_target >= n || graph_edges >= MAX_EDGES)
                graph_dropped = 1'b1;
            else
            begin
                graph_src[graph_edges] = r.edge_source;
                graph_dst[graph_edges] = r.edge_target;
                graph_edges++;
            end
        end
        if (!r.last_edge)
            return;
        fc = 0;
        seen = '0;
        for (int root = 0; root < n; root++)
        begin
            if (seen[root])
                continue;
            seen[root] = 1'b1;
            walk_node[0] = root[5:0];
            walk_cur[0] = 0;
            sp = 1;
            while (sp > 0)
            begin
                u = walk_node[sp-1];
                i = walk_cur[sp-1];
                found = 1'b0;
                t = 0;
                while (i < graph_edges)
                begin
                    s = graph_src[i];
                    t = graph_dst[i];
                    i++;
                    if (s == u && t < n && !seen[t])
                    begin
                        found = 1'b1;
                        break;
                    end
                end
                walk_cur[sp-1] = i;
                if (found && sp < MAX_NODES)
                begin
                    seen[t] = 1'b1;
                    walk_node[sp] = t[5:0];
                    walk_cur[sp] = 0;
                    sp++;
                end
                else
                begin
                    if (fc < MAX_NODES)
                    begin
                        finish_seq[fc] = u[5:0];
                        fc++;
                    end
                    sp--;
                end
            end
        end
        seen = '0;
        comp = 0;
        for (int k = fc; k > 0; k--)
        begin
            v = finish_seq[k-1];
            if (seen[v])
                continue;
            seen[v] = 1'b1;
            add_answer(v, comp);
            walk_node[0] = v[5:0];
            walk_cur[0] = 0;
            sp = 1;
            while (sp > 0)
            begin
                u = walk_node[sp-1];
                s = walk_cur[sp-1];
                found = 1'b0;
                while (s < n)
                begin
                    if (!seen[s] && has_edge(s, u))
                    begin
                        found = 1'b1;
                        break;
                    end
                    s++;
                end
                walk_cur[sp-1] = s + 1;
                if (found && sp < MAX_NODES && answer_len < MAX_NODES)
                begin
                    seen[s] = 1'b1;
                    add_answer(s, comp);
                    walk_node[sp] = s[5:0];
                    walk_cur[sp] = 0;
                    sp++;
                end
                else
                    sp--;
            end
            answer[answer_len-1].component_end = 1'b1;
            comp++;
        end
        if (answer_len > 0)
            answer[answer_len-1].last_result = 1'b1;
        graph_edges = 0;
        graph_dropped = 1'b0;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        scc_pkg::result_req_t w;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
                report("unexpected result node", result_req.node_id, 0);
            else
            begin
                w = pending_results.pop_front();
                if (result_req.node_id !== w.node_id)
                    report("node_id", result_req.node_id, w.node_id);
                if (result_req.component_id !== w.component_id)
                    report("component_id", result_req.component_id, w.component_id);
                if (result_req.component_end !== w.component_end)
                    report("component_end", result_req.component_end, w.component_end);
                if (result_req.last_result !== w.last_result)
                    report("last_result", result_req.last_result, w.last_result);
                if (result_req.dropped_edges !== w.dropped_edges)
                    report("dropped_edges", result_req.dropped_edges, w.dropped_edges);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((edge_valid && edge_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send(scc_pkg::edge_req_t r, bit typed, scc_pkg::result_req_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            edge_valid <= 1'b0;
        end
        @(negedge clk);
        edge_valid <= 1'b1;
        edge_req <= r;
        do
            @(posedge clk);
        while (!edge_ready);
        compute_components(r);
        if (typed)
            pending_results = {pending_results, want};
        else
            for (int i = 0; i < answer_len; i++)
                pending_results = {pending_results, answer[i]};
    endtask

    task automatic drain();
        @(negedge clk);
        edge_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_nodes(logic [6:0] raw);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= raw;
        @(negedge clk);
        cfg_we <= 1'b0;
        set_nodes(raw);
    endtask

    task automatic add_row(bit wr, int val, scc_pkg::edge_req_t r, bit typed,
                           scc_pkg::result_req_t want);
        step_t st;
        st.wr = wr;
        st.val = val[6:0];
        st.req = r;
        st.typed = typed;
        st.want = want;
        plan = {plan, st};
    endtask

    task automatic random_edge(int n, int bad_pct);
        int s, t;
        s = $urandom_range(n - 1);
        t = $urandom_range(n - 1);
        if (n < MAX_NODES && $urandom_range(99) < bad_pct)
        begin
            if ($urandom_range(1))
                s = $urandom_range(MAX_NODES - 1, n);
            else
                t = $urandom_range(MAX_NODES - 1, n);
        end
        send(mk_edge(s, t, 1'b1, 1'b0), 1'b0, '0);
    endtask

    task automatic random_graph(int n, int ecount, ref int items);
        drain();
        write_nodes(n == MAX_NODES && $urandom_range(3) == 0 ? 7'd127 : n[6:0]);
        for (int i = 0; i < ecount; i++)
        begin
            if ($urandom_range(9) == 0)
                send(mk_edge($urandom, $urandom, 1'b0, 1'b0), 1'b0, '0);
            else
                random_edge(n, 8);
            items++;
        end
        if (n > 1 && $urandom_range(9) == 0)
        begin
            drain();
            write_nodes(7'($urandom_range(n - 1, 1)));
        end
        if ($urandom_range(1))
            send(mk_edge($urandom, $urandom, 1'b0, 1'b1), 1'b0, '0);
        else
            send(mk_edge($urandom_range(active_nodes - 1), $urandom_range(active_nodes - 1),
                         1'b1, 1'b1), 1'b0, '0);
        items++;
    endtask

    initial
    begin
        int items, n;
        graph_edges = 0;
        graph_dropped = 1'b0;
        set_nodes(7'd64);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // after reset: 64 single-node components
        add_row(0, 0, mk_edge(0, 0, 0, 1), 0, '0);
        add_row(1, 1, '0, 0, '0);
        add_row(0, 0, mk_edge(63, 63, 0, 1), 1, mk_res(0, 0, 1, 1, 0));
        add_row(0, 0, mk_edge(0, 0, 1, 1), 1, mk_res(0, 0, 1, 1, 0));
        add_row(0, 0, mk_edge(1, 0, 1, 1), 1, mk_res(0, 0, 1, 1, 1));
        add_row(1, 0, '0, 0, '0);
        add_row(0, 0, mk_edge(0, 1, 1, 1), 1, mk_res(0, 0, 1, 1, 1));
        add_row(1, 127, '0, 0, '0);
        add_row(0, 0, mk_edge(63, 0, 1, 0), 0, '0);
        add_row(0, 0, mk_edge(0, 63, 1, 0), 0, '0);
        add_row(0, 0, mk_edge(63, 63, 1, 0), 0, '0);
        add_row(0, 0, mk_edge(0, 1, 1, 1), 0, '0);
        add_row(1, 4, '0, 0, '0);
        add_row(0, 0, mk_edge(0, 1, 1, 0), 0, '0);
        add_row(0, 0, mk_edge(1, 2, 1, 0), 0, '0);
        add_row(0, 0, mk_edge(2, 0, 1, 0), 0, '0);
        add_row(0, 0, mk_edge(2, 3, 1, 0), 0, '0);
        add_row(0, 0, mk_edge(3, 63, 1, 0), 0, '0);
        add_row(0, 0, mk_edge(63, 63, 0, 1), 0, '0);
        // node count lowered with edges already loaded
        add_row(1, 8, '0, 0, '0);
        add_row(0, 0, mk_edge(6, 7, 1, 0), 0, '0);
        add_row(0, 0, mk_edge(7, 6, 1, 0), 0, '0);
        add_row(0, 0, mk_edge(1, 6, 1, 0), 0, '0);
        add_row(0, 0, mk_edge(2, 1, 1, 0), 0, '0);
        add_row(1, 4, '0, 0, '0);
        add_row(0, 0, mk_edge(0, 0, 0, 1), 0, '0);

        send_idle_pct = 15;
        recv_idle_pct = 82;
        foreach (plan[i])
        begin
            if (plan[i].wr)
            begin
                drain();
                write_nodes(plan[i].val);
            end
            else
                send(plan[i].req, plan[i].typed, plan[i].want);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 82 : 0;
            recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 15 : 0;
            items = 0;
            while (items < 50)
            begin
                case ($urandom_range(19))
                    0, 1, 2: n = MAX_NODES;
                    3, 4, 5: n = $urandom_range(63, 11);
                    default: n = $urandom_range(10, 1);
                endcase
                random_graph(n, $urandom_range(n < 6 ? 2 * n : 12), items);
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
